// File: hdl/m4inv_pkg.sv
// Shared widths, types and index helpers for the 4x4 fixed-point matrix inverse.
package m4inv_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ELEM_W    = 15;
  localparam int CF_W      = 46;                  // 3x3 cofactor, signed
  localparam int PROD_W    = CF_W + ELEM_W;       // shared multiplier output
  localparam int DET_W     = 63;                  // determinant, signed
  localparam int NUM_W     = CF_W + 2 * FRAC_BITS; // dividend width
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int OUT_W     = 32;
  localparam int NUM_TERMS = 6;

  localparam logic [OUT_W-1:0] ONE_Q   = OUT_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] POS_SAT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [OUT_W-1:0] quot;
  } div_res_t;

  // column picked by row i of term j in the 3x3 Leibniz expansion
  function automatic logic [1:0] perm_col(input logic [2:0] j, input logic [1:0] i);
    logic [1:0] p;
    case (j)
      3'd0: p = i;
      3'd1: p = (i == 2'd0) ? 2'd0 : ((i == 2'd1) ? 2'd2 : 2'd1);
      3'd2: p = (i == 2'd0) ? 2'd1 : ((i == 2'd1) ? 2'd0 : 2'd2);
      3'd3: p = (i == 2'd0) ? 2'd1 : ((i == 2'd1) ? 2'd2 : 2'd0);
      3'd4: p = (i == 2'd0) ? 2'd2 : ((i == 2'd1) ? 2'd0 : 2'd1);
      3'd5: p = (i == 2'd0) ? 2'd2 : ((i == 2'd1) ? 2'd1 : 2'd0);
      default: p = i;
    endcase
    return p;
  endfunction

  // element address for factor i of term j of minor k (k = skip_row + 4*skip_col)
  function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [2:0] j,
                                           input logic [1:0] i);
    logic [1:0] pc;
    logic [1:0] row;
    logic [1:0] col;
    pc  = perm_col(j, i);
    row = (i < k[1:0]) ? i : i + 2'd1;
    col = (pc < k[3:2]) ? pc : pc + 2'd1;
    return {col, row};
  endfunction

  // odd permutation xor checkerboard sign of the cofactor
  function automatic logic term_neg(input logic [3:0] k, input logic [2:0] j);
    logic odd;
    odd = (j == 3'd1) || (j == 3'd2) || (j == 3'd5);
    return odd ^ k[0] ^ k[2];
  endfunction

endpackage

// File: hdl/m4inv_elem_ram.sv
// 16-entry element store, one write port and one registered read port.
module m4inv_elem_ram
  import m4inv_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [3:0]        waddr,
  input  logic [ELEM_W-1:0] wdata,
  input  logic [3:0]        raddr,
  output logic [ELEM_W-1:0] rdata
);

  logic [ELEM_W-1:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/m4inv_divider.sv
// Restoring divider, one quotient bit per cycle, quotient overflow tracking.
module m4inv_divider
  import m4inv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CF_W-1:0]  num_mag,
  input  logic [DET_W-1:0] den_mag,
  output div_res_t         res
);

  logic [NUM_W-1:0] num_r;
  logic [DET_W-1:0] den_r;
  logic [DET_W-1:0] rem_r;
  logic [OUT_W-1:0] q_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DET_W:0]   rem_sh;
  logic [DET_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = ~diff[DET_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {num_mag, {(2 * FRAC_BITS){1'b0}}};
      den_r <= den_mag;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[DET_W-1:0] : rem_sh[DET_W-1:0];
      q_r   <= {q_r[OUT_W-2:0], ge};
      ovf_r <= ovf_r | q_r[OUT_W-1];
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;

endmodule

// File: hdl/matrix4_inverse.sv
// Top level: 4x4 fixed-point matrix inverse by cofactors and exact division.
//
// Elements are taken one per cycle with start while busy is low, in
// column-major order. After the sixteenth, busy rises: one shared 46x15
// multiplier builds the 16 cofactors term by term and folds the first
// column into the determinant. Each of the 16 results then takes one
// run of the bit-serial divider; when the matrix is singular, the
// identity is sent instead. Each result is shown for one cycle under
// out_valid and cannot be held off; busy falls with the last result.
module matrix4_inverse
  import m4inv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ELEM_W-1:0] in_element,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_inv_element,
  output logic [3:0]              out_position,
  output logic                    out_singular,
  output logic                    out_clipped,
  output logic                    out_last
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_T0   = 4'd1;
  localparam logic [3:0] S_T1   = 4'd2;
  localparam logic [3:0] S_T2   = 4'd3;
  localparam logic [3:0] S_T3   = 4'd4;
  localparam logic [3:0] S_T4   = 4'd5;
  localparam logic [3:0] S_D0   = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_ID   = 4'd10;
  localparam logic [3:0] S_DR   = 4'd11;
  localparam logic [3:0] S_DS   = 4'd12;
  localparam logic [3:0] S_DW   = 4'd13;

  logic [3:0]               state_r, state_nxt;
  logic [3:0]               load_cnt_r;
  logic [3:0]               k_r;
  logic [2:0]               j_r;
  logic [3:0]               p_r;
  logic [ELEM_W-1:0]        a0_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CF_W-1:0]   acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic                     neg_r;

  logic                     accept;
  logic [3:0]               raddr;
  logic [ELEM_W-1:0]        rdata;
  logic signed [CF_W-1:0]   mul_a;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [CF_W-1:0]   acc_base;
  logic signed [CF_W-1:0]   acc_nxt;
  logic signed [DET_W-1:0]  det_nxt;

  logic signed [CF_W-1:0]   cof_mem [16];
  logic signed [CF_W-1:0]   cof_rdata_r;
  logic [3:0]               cof_raddr;

  logic [CF_W-1:0]          cof_mag;
  logic [DET_W-1:0]         det_mag;
  logic                     div_start;
  div_res_t                 div_res;

  logic                     clip_c;
  logic [OUT_W-1:0]         val_c;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_val_r;
  logic [3:0]               out_pos_r;
  logic                     out_sing_r;
  logic                     out_clip_r;

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;

  m4inv_elem_ram u_elem_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (load_cnt_r),
    .wdata (in_element),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (state_r)
      S_T0:    raddr = elem_addr(k_r, j_r, 2'd0);
      S_T1:    raddr = elem_addr(k_r, j_r, 2'd1);
      S_T2:    raddr = elem_addr(k_r, j_r, 2'd2);
      S_D0:    raddr = k_r;
      default: raddr = elem_addr(k_r, j_r, 2'd0);
    endcase
  end

  // shared multiplier: second operand is always the element just read
  always_comb begin
    case (state_r)
      S_T2:    mul_a = {{(CF_W-ELEM_W){a0_r[ELEM_W-1]}}, a0_r};
      S_D1:    mul_a = acc_r;
      default: mul_a = prod_r[CF_W-1:0];
    endcase
  end
  assign mul_p = mul_a * $signed(rdata);

  assign acc_base = (j_r == 3'd0) ? '0 : acc_r;
  assign acc_nxt  = term_neg(k_r, j_r) ? acc_base - prod_r[CF_W-1:0]
                                       : acc_base + prod_r[CF_W-1:0];
  assign det_nxt  = det_r + {{(DET_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // adjugate is the transposed cofactor matrix
  assign cof_raddr = {p_r[1:0], p_r[3:2]};

  always_ff @(posedge clk) begin
    if (state_r == S_T4 && j_r == 3'(NUM_TERMS - 1)) begin
      cof_mem[k_r] <= acc_nxt;
    end
    cof_rdata_r <= cof_mem[cof_raddr];
  end

  assign cof_mag   = cof_rdata_r[CF_W-1] ? CF_W'(-cof_rdata_r) : CF_W'(cof_rdata_r);
  assign det_mag   = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign div_start = (state_r == S_DS);

  m4inv_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (cof_mag),
    .den_mag (det_mag),
    .res     (div_res)
  );

  always_comb begin
    if (neg_r) begin
      clip_c = div_res.ovf || (div_res.quot > NEG_SAT);
      val_c  = clip_c ? NEG_SAT : OUT_W'(-div_res.quot);
    end else begin
      clip_c = div_res.ovf || div_res.quot[OUT_W-1];
      val_c  = clip_c ? POS_SAT : div_res.quot;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (accept && load_cnt_r == 4'd15) state_nxt = S_T0;
      S_T0:   state_nxt = S_T1;
      S_T1:   state_nxt = S_T2;
      S_T2:   state_nxt = S_T3;
      S_T3:   state_nxt = S_T4;
      S_T4: begin
        if (j_r != 3'(NUM_TERMS - 1)) begin
          state_nxt = S_T0;
        end else if (k_r < 4'd4) begin
          state_nxt = S_D0;
        end else if (k_r == 4'd15) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_T0;
        end
      end
      S_D0:   state_nxt = S_D1;
      S_D1:   state_nxt = S_D2;
      S_D2:   state_nxt = S_T0;
      S_CHK:  state_nxt = (det_r == '0) ? S_ID : S_DR;
      S_ID:   if (p_r == 4'd15) state_nxt = S_LOAD;
      S_DR:   state_nxt = S_DS;
      S_DS:   state_nxt = S_DW;
      S_DW: begin
        if (div_res.done) state_nxt = (p_r == 4'd15) ? S_LOAD : S_DR;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      k_r         <= '0;
      j_r         <= '0;
      p_r         <= '0;
      det_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            load_cnt_r <= load_cnt_r + 4'd1;
            if (load_cnt_r == 4'd15) begin
              k_r   <= '0;
              j_r   <= '0;
              p_r   <= '0;
              det_r <= '0;
            end
          end
        end
        S_T4: begin
          if (j_r != 3'(NUM_TERMS - 1)) begin
            j_r <= j_r + 3'd1;
          end else begin
            j_r <= '0;
            if (k_r >= 4'd4 && k_r != 4'd15) k_r <= k_r + 4'd1;
          end
        end
        S_D2: begin
          det_r <= det_nxt;
          k_r   <= k_r + 4'd1;
        end
        S_ID: begin
          out_valid_r <= 1'b1;
          p_r         <= p_r + 4'd1;
        end
        S_DW: begin
          if (div_res.done) begin
            out_valid_r <= 1'b1;
            p_r         <= p_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_T1: a0_r <= rdata;
      S_T2, S_T3, S_D1: prod_r <= mul_p;
      default: ;
    endcase
    if (state_r == S_T4) acc_r <= acc_nxt;
    if (state_r == S_DS) neg_r <= cof_rdata_r[CF_W-1] ^ det_r[DET_W-1];
    if (state_r == S_ID) begin
      out_val_r  <= (p_r[1:0] == p_r[3:2]) ? ONE_Q : '0;
      out_pos_r  <= p_r;
      out_sing_r <= 1'b1;
      out_clip_r <= 1'b0;
    end else if (state_r == S_DW && div_res.done) begin
      out_val_r  <= val_c;
      out_pos_r  <= p_r;
      out_sing_r <= 1'b0;
      out_clip_r <= clip_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inv_element = out_val_r;
  assign out_position    = out_pos_r;
  assign out_singular    = out_sing_r;
  assign out_clipped     = out_clip_r;
  assign out_last        = (out_pos_r == 4'd15);

endmodule

// File: hdl/m4inv_checker.sv
// Port-level checks on the result stream of the matrix inverse.
module m4inv_checker
  import m4inv_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_inv_element,
  input logic [3:0]              out_position,
  input logic                    out_singular,
  input logic                    out_clipped,
  input logic                    out_last
);

  // busy drops together with the last transaction of a run
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy still high on last result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("busy low before last result");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid ||
      (out_position == $past(out_position) + 4'd1))
    else $error("result positions out of order");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_clipped &&
      (out_inv_element == ((out_position[1:0] == out_position[3:2]) ? ONE_Q : '0)))
    else $error("singular result is not the identity");

endmodule

bind matrix4_inverse m4inv_checker u_m4inv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_inv_element (out_inv_element),
  .out_position    (out_position),
  .out_singular    (out_singular),
  .out_clipped     (out_clipped),
  .out_last        (out_last)
);

// File: tb/tb_matrix4_inverse.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
module tb_matrix4_inverse
  import m4inv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [OUT_W-1:0] inv_element;
    logic [3:0]              position;
    logic                    singular;
    logic                    clipped;
    logic                    last;
  } inv_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ELEM_W-1:0] in_element;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_inv_element;
  logic [3:0]               out_position;
  logic                     out_singular;
  logic                     out_clipped;
  logic                     out_last;

  inv_result_t       inverse_queue[$];
  logic signed [63:0] loaded_mat[16];
  int                load_idx;
  int                errors;
  longint            cycle_cnt;

  localparam longint CYCLE_LIMIT = 4_000_000;

  matrix4_inverse u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_element(in_element),
    .out_valid(out_valid), .out_inv_element(out_inv_element),
    .out_position(out_position), .out_singular(out_singular),
    .out_clipped(out_clipped), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [63:0] mat_at(int r, int c);
    return loaded_mat[r + 4 * c];
  endfunction

  function automatic logic signed [63:0] minor_of(int skip_r, int skip_c);
    int rs[3];
    int cs[3];
    int n;
    int m;
    logic signed [63:0] a[3][3];
    n = 0;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != skip_r) begin rs[n] = k; n++; end
      if (k != skip_c) begin cs[m] = k; m++; end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = mat_at(rs[i], cs[j]);
    return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
         - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
         + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
  endfunction

  function automatic logic signed [63:0] cofactor_of(int r, int c);
    logic signed [63:0] m;
    m = minor_of(r, c);
    return ((r + c) % 2) ? -m : m;
  endfunction

  // inverse of the loaded matrix, queued in column-major order
  task automatic predict_inverse();
    logic signed [63:0] det;
    logic signed [63:0] cf;
    logic [127:0]       num;
    logic [127:0]       dmag;
    logic [127:0]       q;
    logic               neg;
    inv_result_t        res;
    det = 0;
    for (int r = 0; r < 4; r++) det += mat_at(r, 0) * cofactor_of(r, 0);
    dmag = det < 0 ? 128'(-det) : 128'(det);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        res.position = 4'(r + 4 * c);
        res.singular = (det == 0);
        res.clipped  = 1'b0;
        res.last     = (r == 3 && c == 3);
        if (det == 0) begin
          res.inv_element = (r == c) ? (OUT_W'(1) << FRAC_BITS) : '0;
        end else begin
          cf  = cofactor_of(c, r);
          neg = (cf < 0) != (det < 0);
          num = (cf < 0 ? 128'(-cf) : 128'(cf)) << (2 * FRAC_BITS);
          q   = num / dmag;
          if (neg) begin
            if (q > 128'h8000_0000) begin q = 128'h8000_0000; res.clipped = 1'b1; end
            res.inv_element = OUT_W'(-q);
          end else begin
            if (q > 128'h7FFF_FFFF) begin q = 128'h7FFF_FFFF; res.clipped = 1'b1; end
            res.inv_element = OUT_W'(q);
          end
        end
        inverse_queue.push_back(res);
      end
  endtask

  // start stays high between back-to-back transactions; it drops only for a gap
  task automatic send_element(input logic signed [ELEM_W-1:0] val, input bit allow_gap = 1);
    int gap;
    if (allow_gap) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start      <= 1'b1;
    in_element <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    loaded_mat[load_idx] = 64'(val);
    load_idx = (load_idx + 1) % 16;
    if (load_idx == 0) predict_inverse();
  endtask

  task automatic send_matrix(input logic signed [ELEM_W-1:0] m[16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (inverse_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_identity_and_extremes();
    logic signed [ELEM_W-1:0] m[16];
    foreach (m[i]) m[i] = (i % 5 == 0) ? 15'sd4096 : 15'sd0;
    send_matrix(m);
    // all elements at the negative extreme: singular
    foreach (m[i]) m[i] = 15'sh4000;
    send_matrix(m);
    // diagonal of the extremes
    foreach (m[i]) m[i] = '0;
    m[0] = 15'sd16383; m[5] = 15'sh4000; m[10] = 15'sd1; m[15] = -15'sd1;
    send_matrix(m);
    // unit diagonal with huge off-diagonal terms saturates both ways
    foreach (m[i]) m[i] = '0;
    m[0] = 15'sd1; m[5] = 15'sd1; m[10] = 15'sd1; m[15] = 15'sd1;
    m[4] = 15'sd16383; m[14] = 15'sh4000;
    send_matrix(m);
  endtask

  task automatic test_singular_rows();
    logic signed [ELEM_W-1:0] m[16];
    foreach (m[i]) m[i] = 15'($urandom);
    for (int c = 0; c < 4; c++) m[1 + 4 * c] = m[4 * c]; // two equal rows
    send_matrix(m);
  endtask

  task automatic test_random(input int n_mats);
    logic signed [ELEM_W-1:0] m[16];
    int kind;
    for (int k = 0; k < n_mats; k++) begin
      kind = $urandom_range(0, 9);
      foreach (m[i]) begin
        case (kind)
          0: m[i] = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'sd0;
          1: m[i] = 15'($urandom_range(0, 6)) - 15'sd3;
          2: m[i] = (i % 5 == 0) ? 15'($urandom) : 15'($urandom_range(0, 15)) - 15'sd8;
          default: m[i] = 15'($urandom);
        endcase
      end
      send_matrix(m);
      if (k == n_mats / 2) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    inv_result_t e;
    if (rst_n && out_valid) begin
      if (inverse_queue.size() == 0) begin
        $display("%0t: unexpected result pos %0d value %0d", $time, out_position,
                 out_inv_element);
        errors++;
      end else begin
        e = inverse_queue.pop_front();
        if (out_inv_element !== e.inv_element || out_position !== e.position ||
            out_singular !== e.singular || out_clipped !== e.clipped ||
            out_last !== e.last) begin
          $display("%0t: mismatch exp val %0d pos %0d sing %0b clip %0b last %0b",
                   $time, e.inv_element, e.position, e.singular, e.clipped, e.last);
          $display("%0t:          act val %0d pos %0d sing %0b clip %0b last %0b",
                   $time, out_inv_element, out_position, out_singular, out_clipped,
                   out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    errors     = 0;
    cycle_cnt  = 0;
    load_idx   = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_element = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_and_extremes();
    test_singular_rows();
    test_random(23);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/m4inv_pkg.sv
hdl/m4inv_elem_ram.sv
hdl/m4inv_divider.sv
hdl/matrix4_inverse.sv
hdl/m4inv_checker.sv
tb/tb_matrix4_inverse.sv
